[hw/rtl/flgh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package flgh_pkg;

  // datapath widths shared by the arithmetic units
  localparam int OPND_W = 64;   // multiplier operand
  localparam int PROD_W = 128;  // full product and dividend
  localparam int DEN_W  = 96;   // divisor
  localparam int QUO_W  = 63;   // quotient before clamping
  localparam int RAD_W  = 98;   // square root radicand
  localparam int ROOT_W = 49;   // square root result

  // one interaction term
  typedef struct packed {
    logic               operation;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic        [15:0] edge_weight;
    logic               last_term;
  } flgh_in_t;

  // gradient and hessian of one vertex
  typedef struct packed {
    logic signed [63:0] grad_x;
    logic signed [63:0] grad_y;
    logic signed [63:0] hess_xx;
    logic signed [63:0] hess_xy;
    logic signed [63:0] hess_yy;
    logic               degenerate;
    logic               saturated;
  } flgh_out_t;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_t;

  typedef enum logic [2:0] {K_MUL, K_DIV, K_SQRT, K_ADD, K_END} kind_t;

  typedef enum logic [3:0] {
    SRC_AX, SRC_AY, SRC_W, SRC_K, SRC_K2, SRC_D32, SRC_AXX, SRC_AYY, SRC_AXY, SRC_Q, SRC_P
  } src_t;

  typedef enum logic [2:0] {NSH_0, NSH_8, NSH_16, NSH_32, NSH_40, NSH_62} nsh_t;

  typedef enum logic [2:0] {DEN_K8, DEN_K, DEN_D2, DEN_D2S29, DEN_KD} den_t;

  typedef enum logic [3:0] {
    DST_P, DST_AXX, DST_AYY, DST_AXY, DST_K2, DST_KD, DST_D32, DST_Q, DST_PART
  } dst_t;

  typedef enum logic [2:0] {ACC_GX, ACC_GY, ACC_HXX, ACC_HXY, ACC_HYY} acc_t;

  typedef enum logic [2:0] {SG_POS, SG_NEG, SG_X, SG_NX, SG_Y, SG_NY, SG_XY} sign_t;

  // operation of one sequencer step
  typedef struct packed {
    kind_t kind;
    src_t  asel;
    src_t  bsel;
    nsh_t  shift;
    den_t  den;
    dst_t  dst;
    acc_t  acc;
    sign_t sign;
  } uop_t;

  localparam uop_t UOP_END = '{kind: K_END, asel: SRC_AX, bsel: SRC_AX, shift: NSH_0,
                               den: DEN_K, dst: DST_P, acc: ACC_GX, sign: SG_POS};

  function automatic uop_t mul_op(src_t a, src_t b, dst_t d);
    uop_t u;
    u = UOP_END;
    u.kind = K_MUL;
    u.asel = a;
    u.bsel = b;
    u.dst  = d;
    return u;
  endfunction

  function automatic uop_t div_op(src_t n, nsh_t sh, den_t dn, dst_t d);
    uop_t u;
    u = UOP_END;
    u.kind  = K_DIV;
    u.asel  = n;
    u.shift = sh;
    u.den   = dn;
    u.dst   = d;
    return u;
  endfunction

  function automatic uop_t add_op(acc_t a, sign_t s);
    uop_t u;
    u = UOP_END;
    u.kind = K_ADD;
    u.acc  = a;
    u.sign = s;
    return u;
  endfunction

  function automatic uop_t sqrt_op();
    uop_t u;
    u = UOP_END;
    u.kind = K_SQRT;
    u.dst  = DST_D32;
    return u;
  endfunction

  // step program: attractive (op 0) and repulsive (op 1) terms
  function automatic uop_t flgh_uop(logic op, logic [4:0] pc);
    uop_t u;
    u = UOP_END;
    if (!op) begin
      unique case (pc)
        5'd0:    u = mul_op(SRC_AX, SRC_AX, DST_AXX);
        5'd1:    u = mul_op(SRC_AY, SRC_AY, DST_AYY);
        5'd2:    u = mul_op(SRC_AX, SRC_AY, DST_AXY);
        5'd3:    u = sqrt_op();
        5'd4:    u = mul_op(SRC_W, SRC_AX, DST_P);
        5'd5:    u = mul_op(SRC_P, SRC_D32, DST_P);
        5'd6:    u = div_op(SRC_P, NSH_0, DEN_K8, DST_PART);
        5'd7:    u = add_op(ACC_GX, SG_X);
        5'd8:    u = mul_op(SRC_W, SRC_AY, DST_P);
        5'd9:    u = mul_op(SRC_P, SRC_D32, DST_P);
        5'd10:   u = div_op(SRC_P, NSH_0, DEN_K8, DST_PART);
        5'd11:   u = add_op(ACC_GY, SG_Y);
        5'd12:   u = mul_op(SRC_W, SRC_D32, DST_P);
        5'd13:   u = div_op(SRC_P, NSH_8, DEN_K, DST_PART);
        5'd14:   u = add_op(ACC_HXX, SG_POS);
        5'd15:   u = add_op(ACC_HYY, SG_POS);
        5'd16:   u = mul_op(SRC_D32, SRC_K, DST_KD);
        5'd17:   u = mul_op(SRC_W, SRC_AXX, DST_P);
        5'd18:   u = div_op(SRC_P, NSH_40, DEN_KD, DST_PART);
        5'd19:   u = add_op(ACC_HXX, SG_POS);
        5'd20:   u = mul_op(SRC_W, SRC_AYY, DST_P);
        5'd21:   u = div_op(SRC_P, NSH_40, DEN_KD, DST_PART);
        5'd22:   u = add_op(ACC_HYY, SG_POS);
        5'd23:   u = mul_op(SRC_W, SRC_AXY, DST_P);
        5'd24:   u = div_op(SRC_P, NSH_40, DEN_KD, DST_PART);
        5'd25:   u = add_op(ACC_HXY, SG_XY);
        default: u = UOP_END;
      endcase
    end else begin
      unique case (pc)
        5'd0:    u = mul_op(SRC_AX, SRC_AX, DST_AXX);
        5'd1:    u = mul_op(SRC_AY, SRC_AY, DST_AYY);
        5'd2:    u = mul_op(SRC_AX, SRC_AY, DST_AXY);
        5'd3:    u = mul_op(SRC_K, SRC_K, DST_K2);
        5'd4:    u = mul_op(SRC_K2, SRC_AX, DST_P);
        5'd5:    u = div_op(SRC_P, NSH_16, DEN_D2, DST_PART);
        5'd6:    u = add_op(ACC_GX, SG_NX);
        5'd7:    u = mul_op(SRC_K2, SRC_AY, DST_P);
        5'd8:    u = div_op(SRC_P, NSH_16, DEN_D2, DST_PART);
        5'd9:    u = add_op(ACC_GY, SG_NY);
        5'd10:   u = div_op(SRC_K2, NSH_32, DEN_D2, DST_PART);
        5'd11:   u = add_op(ACC_HXX, SG_NEG);
        5'd12:   u = add_op(ACC_HYY, SG_NEG);
        5'd13:   u = div_op(SRC_AXX, NSH_62, DEN_D2, DST_Q);
        5'd14:   u = mul_op(SRC_K2, SRC_Q, DST_P);
        5'd15:   u = div_op(SRC_P, NSH_0, DEN_D2S29, DST_PART);
        5'd16:   u = add_op(ACC_HXX, SG_POS);
        5'd17:   u = div_op(SRC_AYY, NSH_62, DEN_D2, DST_Q);
        5'd18:   u = mul_op(SRC_K2, SRC_Q, DST_P);
        5'd19:   u = div_op(SRC_P, NSH_0, DEN_D2S29, DST_PART);
        5'd20:   u = add_op(ACC_HYY, SG_POS);
        5'd21:   u = div_op(SRC_AXY, NSH_62, DEN_D2, DST_Q);
        5'd22:   u = mul_op(SRC_K2, SRC_Q, DST_P);
        5'd23:   u = div_op(SRC_P, NSH_0, DEN_D2S29, DST_PART);
        5'd24:   u = add_op(ACC_HXY, SG_XY);
        default: u = UOP_END;
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/force_layout_grad_hessian.sv]
`timescale 1ns / 1ps
`default_nettype none

// Gradient and 2x2 Hessian accumulator for force-directed layout. Each input item is one
// attractive or repulsive interaction term of the vertex under evaluation; its share is
// added to five saturating Q32.32 sums, and the term flagged last_term delivers the sums
// and both flags as one output item, after which the sums clear. A term's run time is set
// mostly by the shared 63-step restoring divider, which runs six times for an attractive
// term and nine times for a repulsive one, next to a 4-pass 32x32 multiplier and a 49-step
// square root; a zero-distance term uses none of the units. in_stall is high for the whole
// of a term. The output item is held in a register, so a new term may be taken while the
// previous result waits.
module force_layout_grad_hessian
  import flgh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire flgh_in_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output flgh_out_t      out_item,
  input  wire logic      cfg_write,
  input  wire logic [30:0] cfg_data
);

  localparam logic [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SUM_MIN = {1'b1, 63'b0};

  state_t state;
  state_t state_next;
  logic [4:0] pc;
  logic [4:0] pc_next;
  uop_t uop;

  logic [30:0]  spring_length;
  logic         op_r;
  logic         last_r;
  logic         xneg;
  logic         yneg;
  logic [31:0]  ax;
  logic [31:0]  ay;
  logic [15:0]  w;
  logic [63:0]  axx;
  logic [63:0]  ayy;
  logic [63:0]  axy;
  logic [61:0]  k2;
  logic [48:0]  d32;
  logic [79:0]  kd;
  logic [62:0]  q;
  logic [127:0] p;
  logic [62:0]  part;
  logic [65:0]  d2;

  logic [63:0] sum_gx;
  logic [63:0] sum_gy;
  logic [63:0] sum_hxx;
  logic [63:0] sum_hxy;
  logic [63:0] sum_hyy;
  logic        flag_degenerate;
  logic        flag_saturated;

  logic        in_accept;
  logic [32:0] dx_in;
  logic [32:0] dy_in;
  logic [32:0] ax_in;
  logic [32:0] ay_in;
  logic        degen_in;

  logic                mul_start;
  logic                div_start;
  logic                sqrt_start;
  logic                mul_done;
  logic                div_done;
  logic                sqrt_done;
  logic                unit_done;
  logic [OPND_W-1:0]   mul_a;
  logic [OPND_W-1:0]   mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]   div_base;
  logic [PROD_W-1:0]   div_num;
  logic [DEN_W-1:0]    div_den;
  logic [QUO_W-1:0]    div_q;
  logic                div_ovf;
  logic [ROOT_W-1:0]   sqrt_root;
  logic                load_out;

  logic [63:0] acc_cur;
  logic        acc_neg;
  logic [63:0] acc_mag;
  logic [63:0] acc_v;
  logic [63:0] acc_sum;
  logic        acc_ovf;
  logic [63:0] acc_res;

  // operand source for the multiplier and the dividend
  function automatic logic [63:0] pick(src_t s);
    logic [63:0] v;
    v = '0;
    case (s)
      SRC_AX:  v = 64'(ax);
      SRC_AY:  v = 64'(ay);
      SRC_W:   v = 64'(w);
      SRC_K:   v = 64'(spring_length);
      SRC_K2:  v = 64'(k2);
      SRC_D32: v = 64'(d32);
      SRC_AXX: v = axx;
      SRC_AYY: v = ayy;
      SRC_AXY: v = axy;
      SRC_Q:   v = 64'(q);
      SRC_P:   v = p[63:0];
      default: v = '0;
    endcase
    return v;
  endfunction

  // deltas and their magnitudes from the incoming item
  always_comb begin
    in_accept = in_valid && !in_stall;
    dx_in = {in_item.self_x[31], in_item.self_x} - {in_item.other_x[31], in_item.other_x};
    dy_in = {in_item.self_y[31], in_item.self_y} - {in_item.other_y[31], in_item.other_y};
    ax_in = dx_in[32] ? -dx_in : dx_in;
    ay_in = dy_in[32] ? -dy_in : dy_in;
    degen_in = (ax_in == '0) && (ay_in == '0);
  end

  // operand routing for the shared units
  always_comb begin
    uop   = flgh_uop(op_r, pc);
    d2    = 66'(axx) + 66'(ayy);
    mul_a = pick(uop.asel);
    mul_b = pick(uop.bsel);
    div_base = (uop.asel == SRC_P) ? p : PROD_W'(pick(uop.asel));
    case (uop.shift)
      NSH_8:   div_num = div_base << 8;
      NSH_16:  div_num = div_base << 16;
      NSH_32:  div_num = div_base << 32;
      NSH_40:  div_num = div_base << 40;
      NSH_62:  div_num = div_base << 62;
      default: div_num = div_base;
    endcase
    case (uop.den)
      DEN_K8:    div_den = {57'b0, spring_length, 8'b0};
      DEN_K:     div_den = {65'b0, spring_length};
      DEN_D2:    div_den = {30'b0, d2};
      DEN_D2S29: div_den = {1'b0, d2, 29'b0};
      DEN_KD:    div_den = {16'b0, kd};
      default:   div_den = '0;
    endcase
  end

  // saturating add of the current part into one sum
  always_comb begin
    case (uop.acc)
      ACC_GX:  acc_cur = sum_gx;
      ACC_GY:  acc_cur = sum_gy;
      ACC_HXX: acc_cur = sum_hxx;
      ACC_HXY: acc_cur = sum_hxy;
      ACC_HYY: acc_cur = sum_hyy;
      default: acc_cur = '0;
    endcase
    case (uop.sign)
      SG_NEG:  acc_neg = 1'b1;
      SG_X:    acc_neg = xneg;
      SG_NX:   acc_neg = !xneg;
      SG_Y:    acc_neg = yneg;
      SG_NY:   acc_neg = !yneg;
      SG_XY:   acc_neg = xneg ^ yneg;
      default: acc_neg = 1'b0;
    endcase
    acc_mag = {1'b0, part};
    acc_v   = acc_neg ? -acc_mag : acc_mag;
    acc_sum = acc_cur + acc_v;
    acc_ovf = (acc_cur[63] == acc_v[63]) && (acc_sum[63] != acc_cur[63]);
    acc_res = acc_ovf ? (acc_cur[63] ? SUM_MIN : SUM_MAX) : acc_sum;
  end

  // sequencer: next state and unit starts
  always_comb begin
    state_next = state;
    pc_next    = pc;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    unit_done  = mul_done || div_done || sqrt_done;
    unique case (state)
      S_IDLE: begin
        pc_next = '0;
        if (in_valid) begin
          state_next = degen_in ? S_FINISH : S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (uop.kind)
          K_MUL: begin
            mul_start  = 1'b1;
            state_next = S_WAIT;
          end
          K_DIV: begin
            div_start  = 1'b1;
            state_next = S_WAIT;
          end
          K_SQRT: begin
            sqrt_start = 1'b1;
            state_next = S_WAIT;
          end
          K_ADD: begin
            pc_next = pc + 5'd1;
          end
          K_END: begin
            state_next = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_WAIT: begin
        if (unit_done) begin
          pc_next    = pc + 5'd1;
          state_next = S_ISSUE;
        end
      end
      S_FINISH: begin
        if (!last_r) begin
          state_next = S_IDLE;
        end else if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    in_stall = (state != S_IDLE);
  end

  // state, configuration, sums and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pc              <= '0;
      spring_length   <= 31'd65536;
      sum_gx          <= '0;
      sum_gy          <= '0;
      sum_hxx         <= '0;
      sum_hxy         <= '0;
      sum_hyy         <= '0;
      flag_degenerate <= 1'b0;
      flag_saturated  <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cfg_write) begin
        spring_length <= cfg_data;
      end
      if (in_accept && degen_in) begin
        flag_degenerate <= 1'b1;
      end
      if (state == S_WAIT && div_done && uop.dst == DST_PART && div_ovf) begin
        flag_saturated <= 1'b1;
      end
      if (state == S_ISSUE && uop.kind == K_ADD) begin
        if (acc_ovf) begin
          flag_saturated <= 1'b1;
        end
        case (uop.acc)
          ACC_GX:  sum_gx  <= acc_res;
          ACC_GY:  sum_gy  <= acc_res;
          ACC_HXX: sum_hxx <= acc_res;
          ACC_HXY: sum_hxy <= acc_res;
          ACC_HYY: sum_hyy <= acc_res;
          default: sum_gx  <= sum_gx;
        endcase
      end
      if (load_out) begin
        sum_gx          <= '0;
        sum_gy          <= '0;
        sum_hxx         <= '0;
        sum_hxy         <= '0;
        sum_hyy         <= '0;
        flag_degenerate <= 1'b0;
        flag_saturated  <= 1'b0;
      end
      out_valid <= (out_valid && out_stall) || load_out;
    end
  end

  // term operands and intermediate results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_item.operation;
      last_r <= in_item.last_term;
      xneg   <= dx_in[32];
      yneg   <= dy_in[32];
      ax     <= ax_in[31:0];
      ay     <= ay_in[31:0];
      w      <= in_item.edge_weight;
    end
    if (state == S_WAIT && mul_done) begin
      case (uop.dst)
        DST_AXX: axx <= mul_p[63:0];
        DST_AYY: ayy <= mul_p[63:0];
        DST_AXY: axy <= mul_p[63:0];
        DST_K2:  k2  <= mul_p[61:0];
        DST_KD:  kd  <= mul_p[79:0];
        default: p   <= mul_p;
      endcase
    end
    if (state == S_WAIT && div_done) begin
      if (uop.dst == DST_Q) begin
        q <= div_q;
      end else begin
        part <= div_ovf ? {QUO_W{1'b1}} : div_q;
      end
    end
    if (state == S_WAIT && sqrt_done) begin
      d32 <= sqrt_root;
    end
    if (load_out) begin
      out_item.grad_x     <= sum_gx;
      out_item.grad_y     <= sum_gy;
      out_item.hess_xx    <= sum_hxx;
      out_item.hess_xy    <= sum_hxy;
      out_item.hess_yy    <= sum_hyy;
      out_item.degenerate <= flag_degenerate;
      out_item.saturated  <= flag_saturated;
    end
  end

  flgh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  flgh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .ovf   (div_ovf)
  );

  flgh_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   ({d2, 32'b0}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // at most one unit is started at a time
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_start, div_start, sqrt_start}))
    else $error("more than one arithmetic unit started");

  // unit results only arrive while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> state == S_WAIT)
    else $error("unit finished outside the wait state");

  // a result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !(out_valid && out_stall))
    else $error("output item overwritten while stalled");

  // sums and flags are clear after a result is loaded into the output register
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    load_out |=> sum_gx == '0 && sum_hxx == '0 && !flag_saturated && !flag_degenerate)
    else $error("sums not cleared after result");

  // a zero-distance term goes straight to finish with its flag set
  a_degen: assert property (@(posedge clk) disable iff (rst)
    (in_accept && degen_in) |=> state == S_FINISH && flag_degenerate)
    else $error("zero-distance term not skipped");

endmodule

`default_nettype wire

[hw/rtl/flgh_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module flgh_mul
  import flgh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OPND_W-1:0] a,
  input  wire logic [OPND_W-1:0] b,
  output logic                   done,
  output logic [PROD_W-1:0]      prod
);

  localparam int HALF_W = OPND_W / 2;

  logic                busy;
  logic [2:0]          cnt;
  logic [OPND_W-1:0]   a_r;
  logic [OPND_W-1:0]   b_r;
  logic [OPND_W-1:0]   pp;
  logic [1:0]          pp_sh;
  logic [HALF_W-1:0]   a_half;
  logic [HALF_W-1:0]   b_half;
  logic [PROD_W-1:0]   pp_ext;

  // half select for the current partial product
  always_comb begin
    a_half = cnt[1] ? a_r[OPND_W-1:HALF_W] : a_r[HALF_W-1:0];
    b_half = cnt[0] ? b_r[OPND_W-1:HALF_W] : b_r[HALF_W-1:0];
    pp_ext = PROD_W'(pp) << {pp_sh, 5'b0};
  end

  // four 32x32 partial products, each registered before accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp    <= a_half * b_half;
        pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      if (cnt != 3'd0) begin
        prod <= prod + pp_ext;
      end
      if (cnt == 3'd4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt + 3'd1;
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/flgh_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module flgh_div
  import flgh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [QUO_W-1:0]       quo,
  output logic                   ovf
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic              busy;
  logic              chk;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  low;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // one restoring step
  always_comb begin
    trial = {rem, low[QUO_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  // overflow check on the top bits, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      chk   <= 1'b1;
      done  <= 1'b0;
      rem   <= DEN_W'(num[PROD_W-1:QUO_W]);
      low   <= num[QUO_W-1:0];
      den_r <= den;
      quo   <= '0;
    end else if (busy && chk) begin
      chk <= 1'b0;
      if (rem >= den_r) begin
        ovf  <= 1'b1;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        ovf <= 1'b0;
        cnt <= CNT_W'(QUO_W);
      end
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low <= {low[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/flgh_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module flgh_sqrt
  import flgh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] rad,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  t;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  // one root bit from the next pair of radicand bits
  always_comb begin
    t     = {rem, rad_r[RAD_W-1:RAD_W-2]};
    trial = (REM_W+2)'({root, 2'b01});
    diff  = t - trial;
    ge    = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      rad_r <= rad;
      rem   <= '0;
      root  <= '0;
      cnt   <= CNT_W'(ROOT_W);
    end else if (busy) begin
      rem   <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
      root  <= {root[ROOT_W-2:0], ge};
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      cnt   <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire
